@@ rtl/fsct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fsct_pkg;

	// frustum shape
	localparam int NUM_PLANES      = 6;
	localparam int COORD_WIDTH_DEF = 24;

	// plane register packing
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int NORM_W     = 12;
	localparam int OFS_W      = 28;
	localparam int NX_LSB     = 0;
	localparam int NY_LSB     = 12;
	localparam int NZ_LSB     = 24;
	localparam int OFS_LSB    = 36;

	// offset and radius go from 8 to 18 fraction bits
	localparam int FRAC_SHIFT = 10;

	typedef enum logic [1:0] {
		VERDICT_OUTSIDE   = 2'd0,
		VERDICT_INTERSECT = 2'd1,
		VERDICT_INSIDE    = 2'd2
	} verdict_t;

	// stage load enables handed to the plane units
	typedef struct packed {
		logic s2;
		logic s3;
	} fsct_adv_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// product of a normal and a coordinate
	function automatic int prod_w(input int cw);
		return cw + NORM_W;
	endfunction

	// three products plus the scaled offset, exact
	function automatic int dist_w(input int cw);
		return max_int(prod_w(cw) + 2, OFS_W + FRAC_SHIFT) + 1;
	endfunction

	// room for the distance and for plus or minus the scaled radius
	function automatic int cmp_w(input int cw);
		return max_int(dist_w(cw), cw - 1 + FRAC_SHIFT) + 2;
	endfunction

endpackage

`default_nettype wire

@@ rtl/fsct_plane_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fsct_plane_regs (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [fsct_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [fsct_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [fsct_pkg::NUM_PLANES-1:0][fsct_pkg::CFG_DATA_W-1:0] planes
);
	import fsct_pkg::*;

	logic [NUM_PLANES-1:0][CFG_DATA_W-1:0] plane_q;

	// indexes past the last plane are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_PLANES))) begin
			plane_q[cfg_index] <= cfg_data;
		end
	end

	assign planes = plane_q;

endmodule

`default_nettype wire

@@ rtl/fsct_plane_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fsct_plane_eval #(
	parameter int COORD_WIDTH = fsct_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                                      clk,
	input  wire fsct_pkg::fsct_adv_t                       adv,
	input  wire logic [fsct_pkg::CFG_DATA_W-1:0]           plane,
	input  wire logic signed [COORD_WIDTH-1:0]             cx_s1,
	input  wire logic signed [COORD_WIDTH-1:0]             cy_s1,
	input  wire logic signed [COORD_WIDTH-1:0]             cz_s1,
	input  wire logic signed [fsct_pkg::cmp_w(COORD_WIDTH)-1:0] r_pos_s3,
	output logic                                           outside,
	output logic                                           partial
);
	import fsct_pkg::*;

	localparam int PW = prod_w(COORD_WIDTH);
	localparam int DW = dist_w(COORD_WIDTH);
	localparam int CW = cmp_w(COORD_WIDTH);
	localparam int SOW = OFS_W + FRAC_SHIFT;

	logic signed [NORM_W-1:0] nx, ny, nz;
	logic signed [OFS_W-1:0]  ofs;
	logic signed [SOW-1:0]    ofs_scaled;
	logic signed [PW-1:0]     px, py, pz;
	logic signed [PW-1:0]     px_s2, py_s2, pz_s2;
	logic signed [DW-1:0]     dist_sum;
	logic signed [DW-1:0]     dist_s3;
	logic signed [CW-1:0]     dist_ext, r_neg;

	assign nx  = plane[NX_LSB +: NORM_W];
	assign ny  = plane[NY_LSB +: NORM_W];
	assign nz  = plane[NZ_LSB +: NORM_W];
	assign ofs = plane[OFS_LSB +: OFS_W];
	assign ofs_scaled = signed'({ofs, {FRAC_SHIFT{1'b0}}});

	assign px = nx * cx_s1;
	assign py = ny * cy_s1;
	assign pz = nz * cz_s1;

	assign dist_sum = DW'(px_s2) + DW'(py_s2) + DW'(pz_s2) + DW'(ofs_scaled);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			px_s2 <= px;
			py_s2 <= py;
			pz_s2 <= pz;
		end
		if (adv.s3) begin
			dist_s3 <= dist_sum;
		end
	end

	assign dist_ext = CW'(dist_s3);
	assign r_neg    = -r_pos_s3;

	// equal to minus radius counts as intersect, equal to radius as inside
	assign outside = dist_ext < r_neg;
	assign partial = dist_ext < r_pos_s3;

endmodule

`default_nettype wire

@@ rtl/frustum_sphere_cull_test_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  | signals                                         | direction
// ---------+-------------------------------------------------+----------
// in       | in_valid, in_ready, centre_x/y/z, sphere_radius | sink
// out      | out_valid, out_ready, verdict                   | source
// cfg      | cfg_wr_en, cfg_index, cfg_data                  | sink, no wait
//
// one sphere per cycle sustained while out_ready stays high; an input beat
// reaches the result through four registers (input reg, products,
// distance, verdict)
// each stage has its own valid and loads when empty or draining, so
// bubbles close up and a stalled result holds back only the full stages
// reset clears the stage valids and zeroes all six planes

module frustum_sphere_cull_test_unit #(
	parameter int COORD_WIDTH = fsct_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// config
	input  wire logic                              cfg_wr_en,
	input  wire logic [fsct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fsct_pkg::CFG_DATA_W-1:0]   cfg_data,
	// sphere in
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [COORD_WIDTH-1:0]     centre_x,
	input  wire logic signed [COORD_WIDTH-1:0]     centre_y,
	input  wire logic signed [COORD_WIDTH-1:0]     centre_z,
	input  wire logic [COORD_WIDTH-2:0]            sphere_radius,
	// verdict out
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [1:0]                             verdict
);
	import fsct_pkg::*;

	localparam int CW = cmp_w(COORD_WIDTH);

	logic [NUM_PLANES-1:0][CFG_DATA_W-1:0] planes;

	// stage valids and ready chain
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic ready1, ready2, ready3, ready4;
	fsct_adv_t adv;

	// input payload and radius pipeline
	logic signed [COORD_WIDTH-1:0] cx_s1, cy_s1, cz_s1;
	logic [COORD_WIDTH-2:0]        r_s1, r_s2, r_s3;
	logic signed [CW-1:0]          r_pos_s3;

	logic [NUM_PLANES-1:0] outside, partial;
	verdict_t              verdict_d, verdict_q;

	fsct_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	// a stage takes a new beat when it is empty or its beat moves on
	assign ready4   = !out_valid_q || out_ready;
	assign ready3   = !valid_s3 || ready4;
	assign ready2   = !valid_s2 || ready3;
	assign ready1   = !valid_s1 || ready2;
	assign in_ready = ready1;

	assign adv.s2 = ready2;
	assign adv.s3 = ready3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready1) valid_s1    <= in_valid;
			if (ready2) valid_s2    <= valid_s1;
			if (ready3) valid_s3    <= valid_s2;
			if (ready4) out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1) begin
			cx_s1 <= centre_x;
			cy_s1 <= centre_y;
			cz_s1 <= centre_z;
			r_s1  <= sphere_radius;
		end
		if (ready2) r_s2 <= r_s1;
		if (ready3) r_s3 <= r_s2;
		if (ready4) verdict_q <= verdict_d;
	end

	// radius to 18 fraction bits, always non-negative
	assign r_pos_s3 = CW'(signed'({1'b0, r_s3, {FRAC_SHIFT{1'b0}}}));

	// one distance unit per plane
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		fsct_plane_eval #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_eval (
			.clk      (clk),
			.adv      (adv),
			.plane    (planes[p]),
			.cx_s1    (cx_s1),
			.cy_s1    (cy_s1),
			.cz_s1    (cz_s1),
			.r_pos_s3 (r_pos_s3),
			.outside  (outside[p]),
			.partial  (partial[p])
		);
	end

	// outside on any plane wins over intersect on another
	always_comb begin
		if (|outside) begin
			verdict_d = VERDICT_OUTSIDE;
		end else if (|partial) begin
			verdict_d = VERDICT_INTERSECT;
		end else begin
			verdict_d = VERDICT_INSIDE;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule

`default_nettype wire

@@ test/tb_frustum_sphere_cull_test_unit.sv @@
`timescale 1ns / 1ps

// six-plane sphere cull check: spheres stream in, verdicts stream out, and a
// local copy of the six planes predicts each verdict at the input beat

module tb_frustum_sphere_cull_test_unit;

	import fsct_pkg::*;

	localparam int CW          = COORD_WIDTH_DEF;
	localparam int CMAX        = 2 ** (CW - 1) - 1;
	localparam int CMIN        = -(2 ** (CW - 1));
	localparam int RMAX        = 2 ** (CW - 1) - 1;
	localparam int OFS_MAX     = 2 ** (OFS_W - 1) - 1;
	localparam int OFS_MIN     = -(2 ** (OFS_W - 1));
	localparam int ONE         = 1024;           // 1.0 as a Q1.10 normal
	localparam int PIPE_TAIL   = 8;              // four-stage pipe, twice over
	localparam int LONG_HOLD   = 150;            // receiver hold-off, in cycles
	localparam int STALL_LIMIT = 2000;           // cycles with no beat at all
	localparam int PHASE_ITEMS = 200;

	// register indexes, including the two that the block ignores
	typedef enum logic [CFG_IDX_W-1:0] {
		PLANE_NEAR, PLANE_FAR, PLANE_TOP, PLANE_BOTTOM,
		PLANE_LEFT, PLANE_RIGHT, PLANE_SPARE_6, PLANE_SPARE_7
	} plane_idx_t;

	typedef struct {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cz;
		logic [CW-2:0]        rad;
	} sphere_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	// block inputs, all known from time zero
	logic                   cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                   in_valid      = 1'b0;
	logic signed [CW-1:0]   centre_x      = '0;
	logic signed [CW-1:0]   centre_y      = '0;
	logic signed [CW-1:0]   centre_z      = '0;
	logic [CW-2:0]          sphere_radius = '0;
	logic                   out_ready     = 1'b0;
	logic                   in_ready;
	logic                   out_valid;
	logic [1:0]             verdict;

	frustum_sphere_cull_test_unit #(
		.COORD_WIDTH(CW)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.centre_x     (centre_x),
		.centre_y     (centre_y),
		.centre_z     (centre_z),
		.sphere_radius(sphere_radius),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.verdict      (verdict)
	);

	// planes as the block should hold them, and the next set to program
	logic [CFG_DATA_W-1:0] plane_copy [NUM_PLANES] = '{default: '0};
	logic [CFG_DATA_W-1:0] plane_next [NUM_PLANES];

	sphere_t  pending_spheres[$];
	verdict_t expected_verdicts[$];
	int       mismatches = 0;

	// signed distance of the centre to each plane, all at 18 fraction bits
	function automatic verdict_t cull_predict(input sphere_t s);
		longint cx, cy, cz, rr, nx, ny, nz, ofs, dist_val;
		logic [CFG_DATA_W-1:0] p;
		bit outside, partial;
		outside = 1'b0;
		partial = 1'b0;
		cx = s.cx;
		cy = s.cy;
		cz = s.cz;
		rr = s.rad;
		rr = rr * (1 << FRAC_SHIFT);
		for (int i = 0; i < NUM_PLANES; i++) begin
			p    = plane_copy[i];
			nx   = $signed(p[NX_LSB +: NORM_W]);
			ny   = $signed(p[NY_LSB +: NORM_W]);
			nz   = $signed(p[NZ_LSB +: NORM_W]);
			ofs  = $signed(p[OFS_LSB +: OFS_W]);
			dist_val = nx * cx + ny * cy + nz * cz + ofs * (1 << FRAC_SHIFT);
			// touching from inside counts as inside, touching from outside as a cut
			if (dist_val < -rr)
				outside = 1'b1;
			else if (dist_val < rr)
				partial = 1'b1;
		end
		// outside on any plane wins over a cut on another
		if (outside)
			return VERDICT_OUTSIDE;
		else if (partial)
			return VERDICT_INTERSECT;
		return VERDICT_INSIDE;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pack_plane(input int nx, input int ny,
			input int nz, input int ofs);
		logic [NORM_W-1:0] nxv, nyv, nzv;
		logic [OFS_W-1:0]  ofv;
		nxv = nx[NORM_W-1:0];
		nyv = ny[NORM_W-1:0];
		nzv = nz[NORM_W-1:0];
		ofv = ofs[OFS_W-1:0];
		return {ofv, nzv, nyv, nxv};
	endfunction

	// symmetric random value in -m..m
	function automatic int rnd_pm(input int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	task automatic add_sphere(input int x, input int y, input int z, input int r);
		sphere_t s;
		s.cx  = x[CW-1:0];
		s.cy  = y[CW-1:0];
		s.cz  = z[CW-1:0];
		s.rad = r[CW-2:0];
		pending_spheres.push_back(s);
	endtask

	// every bit of every field free
	task automatic add_noise_sphere();
		add_sphere(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
	endtask

	// sender drained and every verdict back, then let the pipe settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_spheres.size() != 0 || in_valid || expected_verdicts.size() != 0);
		repeat (PIPE_TAIL) @(negedge clk);
	endtask

	task automatic write_reg(input plane_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx < NUM_PLANES)
			plane_copy[idx] = data;
	endtask

	// all six planes, plus now and then a write to an index the block ignores
	task automatic commit_planes();
		for (int i = 0; i < NUM_PLANES; i++)
			write_reg(plane_idx_t'(i), plane_next[i]);
		if ($urandom_range(0, 1))
			write_reg($urandom_range(0, 1) ? PLANE_SPARE_6 : PLANE_SPARE_7,
				{$urandom, $urandom});
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// axis-aligned box of half-size half around the origin, tilted a little if asked
	task automatic set_box_planes(input int half, input bit tilted);
		int nrm [NUM_PLANES][3];
		int tilt, ofs;
		nrm = '{'{0, 0, ONE}, '{0, 0, -ONE}, '{0, -ONE, 0},
			'{0, ONE, 0}, '{ONE, 0, 0}, '{-ONE, 0, 0}};
		tilt = tilted ? 64 : 0;
		for (int i = 0; i < NUM_PLANES; i++) begin
			ofs = tilted ? half + rnd_pm(half / 8) : half;
			plane_next[i] = pack_plane(nrm[i][0] + rnd_pm(tilt), nrm[i][1] + rnd_pm(tilt),
				nrm[i][2] + rnd_pm(tilt), ofs);
		end
	endtask

	task automatic fill_box_spheres(input int n, input int half);
		int x, y, z, r, side, face;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 7))
				0: add_noise_sphere();
				1, 2: begin
					// sphere resting on one face, from inside or from outside
					r    = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, half / 2);
					x    = rnd_pm(half / 2);
					y    = rnd_pm(half / 2);
					z    = rnd_pm(half / 2);
					side = $urandom_range(0, 1) ? 1 : -1;
					face = side * ($urandom_range(0, 1) ? half - r : half + r) + rnd_pm(1);
					case ($urandom_range(0, 2))
						0: x = face;
						1: y = face;
						default: z = face;
					endcase
					add_sphere(x, y, z, r);
				end
				default: begin
					r = $urandom_range(0, 5) == 0 ? 0 : $urandom_range(0, half);
					add_sphere(rnd_pm(half * 3 / 2), rnd_pm(half * 3 / 2),
						rnd_pm(half * 3 / 2), r);
				end
			endcase
		end
	endtask

	// planes with free normals; offsets either free or on the scale of the spheres
	task automatic run_free_phase(input int n, input int mag, input bit full_ofs);
		for (int i = 0; i < NUM_PLANES; i++)
			plane_next[i] = pack_plane(int'($urandom), int'($urandom), int'($urandom),
				full_ofs ? int'($urandom) : rnd_pm(mag * 2));
		commit_planes();
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 7) == 0)
				add_noise_sphere();
			else
				add_sphere(rnd_pm(mag), rnd_pm(mag), rnd_pm(mag), $urandom_range(0, mag));
		end
	endtask

	task automatic run_box_phase(input int n, input int half, input bit tilted);
		set_box_planes(half, tilted);
		commit_planes();
		fill_box_spheres(n, half);
	endtask

	// sender: bursts of random length with random gaps, fed from the queue
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin : sphere_driver
		sphere_t s;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			centre_x      <= '0;
			centre_y      <= '0;
			centre_z      <= '0;
			sphere_radius <= '0;
			burst_left    <= 1;
			gap_left      <= 0;
		end else if (!in_valid || in_ready) begin
			// slot is free: either idle through the gap or offer the next beat
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_spheres.size() != 0) begin
				s = pending_spheres.pop_front();
				centre_x      <= s.cx;
				centre_y      <= s.cy;
				centre_z      <= s.cz;
				sphere_radius <= s.rad;
				in_valid      <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// a quarter of the bursts run straight on with no gap
					gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall modes that change every so often, plus two long hold-offs
	int rx_mode, rx_mode_left, rx_pat, rx_hold_left, rx_long_holds, rx_seen;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready     <= 1'b0;
			rx_mode       <= 0;
			rx_mode_left  <= 0;
			rx_pat        <= 0;
			rx_hold_left  <= 0;
			rx_long_holds <= 0;
			rx_seen       <= 0;
		end else begin
			rx_pat <= rx_pat + 1;
			if (out_valid && out_ready)
				rx_seen <= rx_seen + 1;
			if (rx_mode_left == 0) begin
				rx_mode      <= $urandom_range(0, 3);
				rx_mode_left <= $urandom_range(32, 256);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			if (rx_hold_left != 0) begin
				rx_hold_left <= rx_hold_left - 1;
				out_ready    <= 1'b0;
			end else if (rx_long_holds < 2 && rx_seen >= (rx_long_holds + 1) * 700) begin
				// the pipe fills and in_ready has to drop while the sender keeps going
				rx_long_holds <= rx_long_holds + 1;
				rx_hold_left  <= LONG_HOLD;
				out_ready     <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= (rx_pat % 4) == 0;
					default: out_ready <= $urandom_range(0, 7) != 0;
				endcase
			end
		end
	end

	// scoreboard: check the result beat first, then predict for the input beat
	always @(posedge clk) begin : beat_monitor
		sphere_t s;
		verdict_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: verdict %0d with no sphere pending", $time, verdict);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					if (verdict !== want) begin
						$display("%0t: verdict mismatch, expected %0d, actual %0d",
							$time, want, verdict);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				s.cx  = centre_x;
				s.cy  = centre_y;
				s.cz  = centre_z;
				s.rad = sphere_radius;
				expected_verdicts.push_back(cull_predict(s));
			end
		end
	end

	// watchdog on cycles in which neither channel moves a beat
	int quiet_cycles;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("** frustum_sphere_cull_test_unit: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	localparam int B = 1000;   // directed box half-size, Q15.8

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// planes at reset: every distance is zero
		add_sphere(0, 0, 0, 0);
		add_sphere(0, 0, 0, 1);
		add_sphere(CMAX, CMIN, CMAX, RMAX);
		wait_idle();

		// directed box
		set_box_planes(B, 1'b0);
		commit_planes();
		add_sphere(0, 0, 0, 0);
		add_sphere(-B + 100, 0, 0, 100);     // distance equals the radius
		add_sphere(-B - 100, 0, 0, 100);     // distance equals minus the radius
		add_sphere(-B - 101, 0, 0, 100);
		add_sphere(-3000, 950, 0, 100);      // out on the left, cut by the top
		add_sphere(B - 100, 0, 0, 100);
		add_sphere(0, 0, B, 0);              // point on the far plane
		add_sphere(0, 0, B + 1, 0);
		add_sphere(0, 0, 0, RMAX);
		add_sphere(CMAX, CMAX, CMAX, 0);
		add_sphere(CMIN, CMIN, CMIN, RMAX);
		wait_idle();

		// extreme planes, largest then most negative
		for (int i = 0; i < NUM_PLANES; i++)
			plane_next[i] = pack_plane(2047, 2047, 2047, OFS_MAX);
		commit_planes();
		add_sphere(CMAX, CMAX, CMAX, RMAX);
		add_sphere(CMIN, CMIN, CMIN, 0);
		add_sphere(0, 0, 0, RMAX);
		wait_idle();
		for (int i = 0; i < NUM_PLANES; i++)
			plane_next[i] = pack_plane(-2048, -2048, -2048, OFS_MIN);
		commit_planes();
		add_sphere(CMAX, CMAX, CMAX, RMAX);
		add_sphere(CMIN, CMIN, CMIN, 0);
		add_sphere(0, 0, 0, RMAX);
		wait_idle();

		// random part, one plane setting per phase, drained before each rewrite
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 5)
				0: run_box_phase(PHASE_ITEMS,
					$urandom_range(0, 1) ? $urandom_range(16, 1024) : $urandom_range(1024, 65536),
					1'b0);
				1: run_box_phase(PHASE_ITEMS, $urandom_range(256, 65536), 1'b1);
				2: run_free_phase(PHASE_ITEMS, CMAX, 1'b1);
				3: run_free_phase(PHASE_ITEMS, 4096, 1'b0);
				default: run_box_phase(PHASE_ITEMS, $urandom_range(1 << 18, 1 << 20), 1'b0);
			endcase
			wait_idle();
		end

		repeat (PIPE_TAIL) @(negedge clk);
		if (mismatches == 0)
			$display("** frustum_sphere_cull_test_unit: PASSED **");
		else
			$display("** frustum_sphere_cull_test_unit: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/fsct_pkg.sv
rtl/fsct_plane_regs.sv
rtl/fsct_plane_eval.sv
rtl/frustum_sphere_cull_test_unit.sv
test/tb_frustum_sphere_cull_test_unit.sv
